// ===== rtl/core/f2rc_pkg.sv =====
// ----------------------------------------------------------------------------
// f2rc_pkg
// Shared codes of the feature to rainbow color block.
// ----------------------------------------------------------------------------
package f2rc_pkg;

    // action field codes
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_MAP  = 1'b1;

endpackage

// ===== rtl/core/f2rc_if.sv =====
// ----------------------------------------------------------------------------
// f2rc_if
// Valid/ready channels of the feature to rainbow color block.
// ----------------------------------------------------------------------------

// feature item channel
interface f2rc_feat_if #(
    parameter int FEATURE_BITS = 32
);
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic                           first_item;
    logic signed [FEATURE_BITS-1:0] feature_value;

    modport source (output valid, action, first_item, feature_value, input ready);
    modport sink   (input valid, action, first_item, feature_value, output ready);
endinterface

// color result channel
interface f2rc_color_if #(
    parameter int COLOR_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  span_zero;
    logic                  clamped;

    modport source (output valid, red, green, blue, span_zero, clamped, input ready);
    modport sink   (input valid, red, green, blue, span_zero, clamped, output ready);
endinterface

// ===== rtl/core/f2rc_div.sv =====
// ----------------------------------------------------------------------------
// f2rc_div
// Radix-2 restoring divider, one quotient bit per cycle.
// Gives floor(num * 2^QBITS / den) for num < den.
// ----------------------------------------------------------------------------
module f2rc_div #(
    parameter int WIDTH = 32,
    parameter int QBITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] num,
    input  logic [WIDTH-1:0] den,
    output logic             done,
    output logic [QBITS-1:0] quot
);

    localparam int CW = $clog2(QBITS + 1);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] den_reg;
    logic [QBITS-1:0] quot_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // one trial subtraction
    logic [WIDTH:0] shifted;
    logic           fits;
    logic [WIDTH:0] diff;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QBITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            quot_reg <= {quot_reg[QBITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/core/f2rc_ramp.sv =====
// ----------------------------------------------------------------------------
// f2rc_ramp
// Blue-cyan-green-yellow-red ramp and scaling to color codes, two stages.
// ----------------------------------------------------------------------------
module f2rc_ramp #(
    parameter int NORM_BITS  = 16,
    parameter int COLOR_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NORM_BITS:0]    t,
    output logic                  done,
    output logic [COLOR_BITS-1:0] red,
    output logic [COLOR_BITS-1:0] green,
    output logic [COLOR_BITS-1:0] blue
);

    localparam int TW = NORM_BITS + 1;
    localparam int WW = NORM_BITS + 3;
    localparam int PW = NORM_BITS + 1 + COLOR_BITS;

    localparam logic [TW-1:0] T_ONE   = TW'(1) << NORM_BITS;
    localparam logic [TW-1:0] T_QUART = TW'(1) << (NORM_BITS - 2);
    localparam logic [TW-1:0] T_HALF  = TW'(1) << (NORM_BITS - 1);
    localparam logic [TW-1:0] T_3QRT  = T_HALF + T_QUART;
    localparam logic [WW-1:0] W_ONE   = WW'(1) << NORM_BITS;
    localparam logic [PW-1:0] ROUND   = PW'(1) << (NORM_BITS - 1);

    logic [TW-1:0] r_reg, g_reg, b_reg;
    logic          v1_reg;
    logic [COLOR_BITS-1:0] red_reg, green_reg, blue_reg;
    logic          done_reg;

    // piecewise ramp in t units
    logic [WW-1:0] t4;
    logic [TW-1:0] r_next, g_next, b_next;
    logic [WW-1:0] b_fall, r_rise, g_fall;

    assign t4     = {t, 2'b00};
    assign b_fall = (W_ONE << 1) - t4;
    assign r_rise = t4 - (W_ONE << 1);
    assign g_fall = (W_ONE << 2) - t4;

    always_comb
    begin
        if (t <= T_QUART)
        begin
            r_next = '0;
            g_next = t4[TW-1:0];
            b_next = T_ONE;
        end
        else if (t <= T_HALF)
        begin
            r_next = '0;
            g_next = T_ONE;
            b_next = b_fall[TW-1:0];
        end
        else if (t <= T_3QRT)
        begin
            r_next = r_rise[TW-1:0];
            g_next = T_ONE;
            b_next = '0;
        end
        else
        begin
            r_next = T_ONE;
            g_next = g_fall[TW-1:0];
            b_next = '0;
        end
    end

    // scale by full-scale code, round half up: v*(2^C-1) = (v << C) - v
    function automatic logic [COLOR_BITS-1:0] scale(input logic [TW-1:0] v);
        logic [PW-1:0] p;
        p = (PW'(v) << COLOR_BITS) - PW'(v) + ROUND;
        return p[NORM_BITS +: COLOR_BITS];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    // ramp stage, then scaling stage
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
        if (v1_reg)
        begin
            red_reg   <= scale(r_reg);
            green_reg <= scale(g_reg);
            blue_reg  <= scale(b_reg);
        end
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// ===== rtl/core/feature_to_rainbow_color.sv =====
// ----------------------------------------------------------------------------
// feature_to_rainbow_color
// Running min/max of point features and min/max-normalized rainbow colormap.
// ----------------------------------------------------------------------------
// Scan transfers: one per cycle while idle, min/max updated at the transfer.
// Map transfers: the item goes through setup, the radix-2 divider that yields
//   one quotient bit per cycle and the ramp, then waits for the output
//   register; no new item is taken until its result is loaded.
// Reset: min and max clear to zero, no result pending, input ready.
// ----------------------------------------------------------------------------
module feature_to_rainbow_color #(
    parameter int FEATURE_BITS = 32,
    parameter int NORM_BITS    = 16,
    parameter int COLOR_BITS   = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    f2rc_feat_if.sink    feat,
    f2rc_color_if.source color
);

    localparam int FB = FEATURE_BITS;
    localparam int TW = NORM_BITS + 1;
    localparam logic [FB-1:0] SIGN  = FB'(1) << (FB - 1);
    localparam logic [TW-1:0] T_ONE = TW'(1) << NORM_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_COLOR,
        S_PUSH
    } state_t;

    state_t state_reg;

    logic [FB-1:0] min_reg;
    logic [FB-1:0] max_reg;
    logic [FB-1:0] feat_reg;
    logic          span_zero_reg;
    logic          clamped_reg;
    logic          full_reg;

    logic                  out_valid_reg;
    logic [COLOR_BITS-1:0] red_reg, green_reg, blue_reg;
    logic                  out_span_zero_reg, out_clamped_reg;

    logic in_xfer, out_xfer, out_load;

    assign feat.ready = (state_reg == S_IDLE);
    assign in_xfer    = feat.valid && feat.ready;
    assign out_xfer   = out_valid_reg && color.ready;
    assign out_load   = (state_reg == S_PUSH) && (!out_valid_reg || color.ready);

    // order keys: flip the sign bit so unsigned compare follows signed order
    logic [FB-1:0] k_in, k_min, k_max, k_feat;

    assign k_in   = feat.feature_value ^ SIGN;
    assign k_min  = min_reg ^ SIGN;
    assign k_max  = max_reg ^ SIGN;
    assign k_feat = feat_reg ^ SIGN;

    // clamp and operands for the divider
    logic          below, above;
    logic [FB-1:0] k_clamp, div_num, div_den;

    assign below   = (k_feat < k_min);
    assign above   = (k_feat > k_max);
    assign k_clamp = below ? k_min : (above ? k_max : k_feat);
    assign div_num = k_clamp - k_min;
    assign div_den = k_max - k_min;

    // divider and ramp
    logic                 div_start, div_done;
    logic [NORM_BITS-1:0] quot;
    logic                 ramp_start, ramp_done;
    logic [TW-1:0]        t_val;
    logic [COLOR_BITS-1:0] ramp_red, ramp_green, ramp_blue;

    assign div_start  = (state_reg == S_SETUP);
    assign ramp_start = (state_reg == S_DIV) && div_done;
    assign t_val      = span_zero_reg ? '0 : (full_reg ? T_ONE : {1'b0, quot});

    f2rc_div #(
        .WIDTH (FB),
        .QBITS (NORM_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    f2rc_ramp #(
        .NORM_BITS  (NORM_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_ramp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ramp_start),
        .t     (t_val),
        .done  (ramp_done),
        .red   (ramp_red),
        .green (ramp_green),
        .blue  (ramp_blue)
    );

    // state, min/max and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_reg       <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (feat.action == f2rc_pkg::ACT_SCAN)
                        begin
                            if (feat.first_item)
                            begin
                                min_reg <= feat.feature_value;
                                max_reg <= feat.feature_value;
                            end
                            else
                            begin
                                if (k_in < k_min)
                                begin
                                    min_reg <= feat.feature_value;
                                end
                                if (k_in > k_max)
                                begin
                                    max_reg <= feat.feature_value;
                                end
                            end
                        end
                        else
                        begin
                            state_reg <= S_SETUP;
                        end
                    end
                end
                S_SETUP:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_COLOR;
                    end
                end
                S_COLOR:
                begin
                    if (ramp_done)
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            feat_reg <= feat.feature_value;
        end
        if (state_reg == S_SETUP)
        begin
            span_zero_reg <= (k_max == k_min);
            clamped_reg   <= below || above;
            full_reg      <= (k_clamp == k_max);
        end
        if (out_load)
        begin
            red_reg           <= ramp_red;
            green_reg         <= ramp_green;
            blue_reg          <= ramp_blue;
            out_span_zero_reg <= span_zero_reg;
            out_clamped_reg   <= clamped_reg;
        end
    end

    assign color.valid     = out_valid_reg;
    assign color.red       = red_reg;
    assign color.green     = green_reg;
    assign color.blue      = blue_reg;
    assign color.span_zero = out_span_zero_reg;
    assign color.clamped   = out_clamped_reg;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the feature to rainbow color block. Scan and map
// transfers are driven on the feature channel. A scoreboard tracks the running
// min/max and works out the expected color of every map transfer. Each color
// transfer is checked field by field against the oldest expected color.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 850;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 500;
    localparam int CALM_FROM    = 250;
    localparam int CALM_TO      = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       span_zero;
        logic       clamped;
    } color_t;

    // ------------------------------------------------------------------------
    // Scoreboard: running min/max, colormap prediction, result checking
    // ------------------------------------------------------------------------
    class rainbow_scoreboard;
        logic signed [31:0] lo_bound;
        logic signed [31:0] hi_bound;
        color_t             expected_colors[$];
        int                 errors;

        function new();
            lo_bound = '0;
            hi_bound = '0;
            errors   = 0;
        endfunction

        // Scale a Q1.16 channel level to an 8-bit code, rounding half up
        function logic [7:0] to_code(longint unsigned level);
            return 8'((level * 255 + 32768) >> 16);
        endfunction

        function color_t predict_color(logic signed [31:0] f);
            localparam longint unsigned ONE     = 64'd65536;
            localparam longint unsigned QUARTER = 64'd16384;
            color_t             c;
            logic signed [31:0] fc;
            logic [31:0]        span;
            logic [31:0]        offset;
            longint unsigned    t;
            longint unsigned    r;
            longint unsigned    g;
            longint unsigned    b;

            // clamp into the stored range
            c.clamped = 1'b0;
            fc        = f;
            if (f < lo_bound) begin
                fc        = lo_bound;
                c.clamped = 1'b1;
            end else if (f > hi_bound) begin
                fc        = hi_bound;
                c.clamped = 1'b1;
            end
            span        = 32'(hi_bound - lo_bound);
            offset      = 32'(fc - lo_bound);
            c.span_zero = (span == 0);

            // truncated quotient, t = 1.0 when the feature sits on the max
            if (c.span_zero)
                t = 0;
            else if (offset >= span)
                t = ONE;
            else
                t = ({32'd0, offset} << 16) / {32'd0, span};

            // blue - cyan - green - yellow - red
            if (t <= QUARTER) begin
                r = 0; g = 4 * t; b = ONE;
            end else if (t <= 2 * QUARTER) begin
                r = 0; g = ONE; b = ONE - 4 * (t - QUARTER);
            end else if (t <= 3 * QUARTER) begin
                r = 4 * (t - 2 * QUARTER); g = ONE; b = 0;
            end else begin
                r = ONE; g = ONE - 4 * (t - 3 * QUARTER); b = 0;
            end
            c.red   = to_code(r);
            c.green = to_code(g);
            c.blue  = to_code(b);
            return c;
        endfunction

        // Called on every accepted feature transfer
        function void note_feature(logic act, logic first, logic signed [31:0] f);
            if (act == f2rc_pkg::ACT_SCAN) begin
                if (first) begin
                    lo_bound = f;
                    hi_bound = f;
                end else begin
                    if (f < lo_bound) lo_bound = f;
                    if (f > hi_bound) hi_bound = f;
                end
            end else begin
                expected_colors = {expected_colors, predict_color(f)};
            end
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Called on every accepted color transfer
        function void check_color(color_t got);
            color_t exp_c;
            if (expected_colors.size() == 0) begin
                $error("color transfer with no map item outstanding");
                errors++;
                return;
            end
            exp_c = expected_colors.pop_front();
            compare_field("red", exp_c.red, got.red);
            compare_field("green", exp_c.green, got.green);
            compare_field("blue", exp_c.blue, got.blue);
            compare_field("span_zero", exp_c.span_zero, got.span_zero);
            compare_field("clamped", exp_c.clamped, got.clamped);
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    f2rc_feat_if  #(.FEATURE_BITS(32)) feat ();
    f2rc_color_if #(.COLOR_BITS(8))    color ();

    feature_to_rainbow_color #(
        .FEATURE_BITS (32),
        .NORM_BITS    (16),
        .COLOR_BITS   (8)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .feat  (feat),
        .color (color)
    );

    rainbow_scoreboard sb = new();

    int features_sent = 0;
    bit calm          = 0;
    bit hold_req      = 0;
    int quiet_cycles  = 0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Feature side driver
    // ------------------------------------------------------------------------
    task automatic send_feature(logic act, logic first, logic signed [31:0] f);
        while (!calm && $urandom_range(0, 99) < 24) begin
            feat.valid <= 1'b0;
            @(posedge clk);
        end
        feat.valid         <= 1'b1;
        feat.action        <= act;
        feat.first_item    <= first;
        feat.feature_value <= f;
        do @(posedge clk); while (!feat.ready);
        sb.note_feature(act, first, f);
        features_sent++;
        calm = (features_sent >= CALM_FROM && features_sent < CALM_TO);
        if (features_sent == HOLD_AT)
            hold_req = 1;
    endtask

    // Value drawn from one of a few shapes so that ranges vary widely
    function automatic logic signed [31:0] pick_value(int shape, logic signed [31:0] anchor);
        case (shape)
            0:       return $urandom;
            1:       return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
            2:       return anchor;
            default: return anchor + $signed(32'($urandom_range(0, 64))) - 32'sd32;
        endcase
    endfunction

    // Map feature: mostly inside the stored range, some on the bounds, some outside
    function automatic logic signed [31:0] pick_map_value();
        longint unsigned span;
        int              sel;
        span = 64'($unsigned(sb.hi_bound - sb.lo_bound));
        sel  = $urandom_range(0, 99);
        if (sel < 70)
            return sb.lo_bound + 32'({$urandom, $urandom} % (span + 1));
        else if (sel < 78)
            return sb.lo_bound;
        else if (sel < 86)
            return sb.hi_bound;
        else
            return $urandom;
    endfunction

    // Scan set with random content followed by maps, or noise
    task automatic random_sequence();
        logic signed [31:0] anchor;
        int                 shape;
        int                 n;
        if ($urandom_range(0, 99) < 80) begin
            shape  = $urandom_range(0, 3);
            anchor = pick_value(shape == 2 ? 0 : shape, 32'sd0);
            send_feature(f2rc_pkg::ACT_SCAN, 1'b1, anchor);
            n = $urandom_range(0, 5);
            repeat (n) send_feature(f2rc_pkg::ACT_SCAN, 1'($urandom), pick_value(shape, anchor))
                ;
            n = $urandom_range(1, 8);
            repeat (n) send_feature(f2rc_pkg::ACT_MAP, 1'($urandom), pick_map_value());
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_feature(1'($urandom), 1'($urandom), $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Color side: random stalls plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        color.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                color.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end else begin
                color.ready <= calm || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && color.valid && color.ready)
            sb.check_color('{color.red, color.green, color.blue,
                             color.span_zero, color.clamped});
    end

    // Watchdog on cycles with no transfer on either channel
    initial begin
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((feat.valid && feat.ready) || (color.valid && color.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        feat.valid         <= 1'b0;
        feat.action        <= f2rc_pkg::ACT_SCAN;
        feat.first_item    <= 1'b0;
        feat.feature_value <= '0;
        rst_n              <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // map before any scan: zero span around the reset value
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd0);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, -32'sd1);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'h7fff_ffff);
        // scans without a restart fold into the reset min/max
        send_feature(f2rc_pkg::ACT_SCAN, 1'b0, 32'sd100);
        send_feature(f2rc_pkg::ACT_SCAN, 1'b0, -32'sd100);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, -32'sd100);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd100);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd0);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd200);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, -32'sd101);
        // range 0..4 puts maps right on the ramp knees
        send_feature(f2rc_pkg::ACT_SCAN, 1'b1, 32'sd0);
        send_feature(f2rc_pkg::ACT_SCAN, 1'b0, 32'sd4);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd1);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd2);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd3);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd4);
        // zero span after a restart
        send_feature(f2rc_pkg::ACT_SCAN, 1'b1, 32'sd7);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd7);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd8);
        // full signed range
        send_feature(f2rc_pkg::ACT_SCAN, 1'b1, 32'h8000_0000);
        send_feature(f2rc_pkg::ACT_SCAN, 1'b0, 32'h7fff_ffff);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'h8000_0000);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'h7fff_ffff);
        send_feature(f2rc_pkg::ACT_MAP, 1'b0, 32'sd0);
        // first_item on a map transfer has no effect
        send_feature(f2rc_pkg::ACT_MAP, 1'b1, -32'sd1);

        while (features_sent < 25 + RANDOM_ITEMS)
            random_sequence();
        feat.valid <= 1'b0;

        // drain, then let the pipeline settle
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
